[src/assert_macros.svh]
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[src/bcls_pkg.sv]
// ----------------------------------------------------------------------------
// Block command latency statistics package
// Shared widths, codes and types for the statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bcls_pkg;

   localparam int CMD_W   = 32;
   localparam int DUR_W   = 48;
   localparam int BYTE_W  = 64;
   localparam int STAT_W  = 64;
   localparam int CODE_W  = 8;
   localparam int MASK_W  = 32;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_CAT = 6;
   localparam int NUM_REC = 12;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   localparam logic [2:0] CAT_READ   = 3'd0;
   localparam logic [2:0] CAT_WRITE  = 3'd1;
   localparam logic [2:0] CAT_FLUSH  = 3'd2;
   localparam logic [2:0] CAT_TRIM   = 3'd3;
   localparam logic [2:0] CAT_BEFORE = 3'd4;
   localparam logic [2:0] CAT_AFTER  = 3'd5;
   localparam logic [2:0] CAT_ALL    = 3'd6;

   localparam logic [1:0] OUT_FAIL = 2'd0;
   localparam logic [1:0] OUT_OK   = 2'd1;
   localparam logic [1:0] OUT_BOTH = 2'd2;

   localparam logic [2:0] CTR_CALLS = 3'd0;
   localparam logic [2:0] CTR_TIME  = 3'd1;
   localparam logic [2:0] CTR_BYTES = 3'd2;
   localparam logic [2:0] CTR_MAX   = 3'd3;
   localparam logic [2:0] CTR_MIN   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_READ_CODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_CODE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLUSH_CODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_CODE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BEFORE_MASK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AFTER_MASK  = 3'd5;

   typedef struct packed {
      logic [CODE_W-1:0] read_code;
      logic [CODE_W-1:0] write_code;
      logic [CODE_W-1:0] flush_code;
      logic [CODE_W-1:0] trim_code;
      logic [MASK_W-1:0] before_mask;
      logic [MASK_W-1:0] after_mask;
   } cfg_type;

   typedef struct packed {
      logic [2:0] cat;
      logic       bad;
   } query_ctl_type;

   typedef logic [NUM_CAT-1:0][STAT_W-1:0] lanes_type;

endpackage
`default_nettype wire

[src/bcls_if.sv]
// ----------------------------------------------------------------------------
// Block command latency statistics channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface bcls_req_if import bcls_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic              succeeded;
   logic [CMD_W-1:0]  command_word;
   logic [DUR_W-1:0]  duration;
   logic [BYTE_W-1:0] byte_count;
   logic [2:0]        query_category;
   logic [1:0]        query_outcome;
   logic [2:0]        query_counter;

   modport source (output valid, opcode, succeeded, command_word, duration, byte_count,
                   query_category, query_outcome, query_counter, input ready);
   modport sink (input valid, opcode, succeeded, command_word, duration, byte_count,
                 query_category, query_outcome, query_counter, output ready);
endinterface

interface bcls_rsp_if import bcls_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] stat_value;
   logic              query_invalid;

   modport source (output valid, stat_value, query_invalid, input ready);
   modport sink (input valid, stat_value, query_invalid, output ready);
endinterface
`default_nettype wire

[src/bcls_bank.sv]
// ----------------------------------------------------------------------------
// Statistics record bank
// Twelve records, updated by record beats, plus per-category query lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bcls_bank import bcls_pkg::*; #(
   parameter int LATENCY_BITS = 48
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              upd_en,
   input  wire logic              clr_en,
   input  wire cfg_type           cfg,
   input  wire logic              ok,
   input  wire logic [CMD_W-1:0]  cmd,
   input  wire logic [DUR_W-1:0]  dur,
   input  wire logic [BYTE_W-1:0] bytes_in,
   input  wire logic [1:0]        outc,
   input  wire logic [2:0]        ctr,
   output lanes_type              lanes
);

   localparam logic [STAT_W-1:0] LatMask = (64'd1 << LATENCY_BITS) - 64'd1;
   localparam logic [LATENCY_BITS-1:0] LatOnes = LatMask[LATENCY_BITS-1:0];
   localparam int PadW = STAT_W - LATENCY_BITS;

   logic [STAT_W-1:0]       call_ff [NUM_REC];
   logic [STAT_W-1:0]       time_ff [NUM_REC];
   logic [STAT_W-1:0]       byte_ff [NUM_REC];
   logic [LATENCY_BITS-1:0] max_ff  [NUM_REC];
   logic [LATENCY_BITS-1:0] min_ff  [NUM_REC];

   logic [NUM_CAT-1:0]      cat_hit;
   logic [NUM_REC-1:0]      rec_hit;
   logic [STAT_W-1:0]       dur_ext;
   logic [LATENCY_BITS-1:0] lat;

   function automatic logic [STAT_W-1:0] combine(input logic [STAT_W-1:0] a,
                                                 input logic [STAT_W-1:0] b,
                                                 input logic [1:0] oc,
                                                 input logic [2:0] cs);
      logic [STAT_W-1:0] r;
      if (oc == OUT_FAIL) begin
         r = a;
      end else if (oc == OUT_OK) begin
         r = b;
      end else if (cs == CTR_MAX) begin
         r = (a > b) ? a : b;
      end else if (cs == CTR_MIN) begin
         r = (a < b) ? a : b;
      end else begin
         r = a + b;
      end
      return r;
   endfunction

   assign dur_ext = {{(STAT_W-DUR_W){1'b0}}, dur};
   assign lat     = (dur_ext > LatMask) ? LatOnes : dur_ext[LATENCY_BITS-1:0];

   always_comb begin
      cat_hit = '0;
      if (cmd[CODE_W-1:0] == cfg.write_code) begin
         cat_hit[CAT_WRITE] = 1'b1;
      end else if (cmd[CODE_W-1:0] == cfg.read_code) begin
         cat_hit[CAT_READ] = 1'b1;
      end else if (cmd[CODE_W-1:0] == cfg.flush_code) begin
         cat_hit[CAT_FLUSH] = 1'b1;
      end else if (cmd[CODE_W-1:0] == cfg.trim_code) begin
         cat_hit[CAT_TRIM] = 1'b1;
      end
      cat_hit[CAT_BEFORE] = (cmd & cfg.before_mask) == cfg.before_mask;
      cat_hit[CAT_AFTER]  = (cmd & cfg.after_mask) == cfg.after_mask;
   end

   for (genvar r = 0; r < NUM_REC; r++) begin : g_hit
      assign rec_hit[r] = upd_en && cat_hit[r / 2] && (ok == 1'(r % 2));
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < NUM_REC; r++) begin
         if (reset || clr_en) begin
            call_ff[r] <= '0;
            time_ff[r] <= '0;
            byte_ff[r] <= '0;
            max_ff[r]  <= '0;
            min_ff[r]  <= LatOnes;
         end else if (rec_hit[r]) begin
            call_ff[r] <= call_ff[r] + 64'd1;
            time_ff[r] <= time_ff[r] + dur_ext;
            byte_ff[r] <= byte_ff[r] + bytes_in;
            if (lat > max_ff[r]) begin
               max_ff[r] <= lat;
            end
            if (lat < min_ff[r]) begin
               min_ff[r] <= lat;
            end
         end
      end
   end

   for (genvar c = 0; c < NUM_CAT; c++) begin : g_lane
      logic [STAT_W-1:0] a;
      logic [STAT_W-1:0] b;
      always_comb begin
         case (ctr)
            CTR_CALLS: begin
               a = call_ff[2*c];
               b = call_ff[2*c+1];
            end
            CTR_TIME: begin
               a = time_ff[2*c];
               b = time_ff[2*c+1];
            end
            CTR_BYTES: begin
               a = byte_ff[2*c];
               b = byte_ff[2*c+1];
            end
            CTR_MAX: begin
               a = {{PadW{1'b0}}, max_ff[2*c]};
               b = {{PadW{1'b0}}, max_ff[2*c+1]};
            end
            default: begin
               a = {{PadW{1'b0}}, min_ff[2*c]};
               b = {{PadW{1'b0}}, min_ff[2*c+1]};
            end
         endcase
         lanes[c] = combine(a, b, outc, ctr);
      end
   end

   `ASSERT_CLK(a_clear_min, clock, reset, clr_en |=> min_ff[0] == LatOnes, "clear left min set")
   `ASSERT_CLK(a_count_step, clock, reset, rec_hit[0] && !clr_en |=> call_ff[0] == $past(call_ff[0]) + 64'd1, "call count missed a beat")
   `ASSERT_CLK(a_max_ge_min, clock, reset, call_ff[1] != 64'd0 |-> max_ff[1] >= min_ff[1], "max below min")
   `ASSERT_NEVER(a_two_ops, clock, reset, $countones(cat_hit[CAT_TRIM:CAT_READ]) > 1, "several operation hits")

endmodule
`default_nettype wire

[src/bcls_query.sv]
// ----------------------------------------------------------------------------
// Query result pipeline
// Register lanes, select or sum categories and hold the response beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bcls_query import bcls_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire query_ctl_type in_ctl,
   input  wire lanes_type     in_lanes,
   output logic               in_ready,
   bcls_rsp_if.source         rsp_if
);

   logic              s2_v_ff, s2_v_in;
   lanes_type         s2_lanes_ff;
   query_ctl_type     s2_ctl_ff;
   logic              s3_v_ff, s3_v_in;
   logic [STAT_W-1:0] s3_p01_ff, s3_p23_ff, s3_sel_ff, s3_sel_in;
   logic              s3_all_ff, s3_bad_ff;
   logic              out_v_ff, out_v_in;
   logic [STAT_W-1:0] out_val_ff, out_val_in;
   logic              out_bad_ff;
   logic              s2_adv, s3_adv, out_free;

   assign out_free = !out_v_ff || rsp_if.ready;
   assign s3_adv   = s3_v_ff && out_free;
   assign s2_adv   = s2_v_ff && (!s3_v_ff || s3_adv);
   assign in_ready = !s2_v_ff || s2_adv;

   assign s2_v_in  = in_valid || (s2_v_ff && !s2_adv);
   assign s3_v_in  = s2_adv || (s3_v_ff && !s3_adv);
   assign out_v_in = s3_adv || (out_v_ff && !rsp_if.ready);

   always_comb begin
      case (s2_ctl_ff.cat)
         CAT_READ:   s3_sel_in = s2_lanes_ff[CAT_READ];
         CAT_WRITE:  s3_sel_in = s2_lanes_ff[CAT_WRITE];
         CAT_FLUSH:  s3_sel_in = s2_lanes_ff[CAT_FLUSH];
         CAT_TRIM:   s3_sel_in = s2_lanes_ff[CAT_TRIM];
         CAT_BEFORE: s3_sel_in = s2_lanes_ff[CAT_BEFORE];
         CAT_AFTER:  s3_sel_in = s2_lanes_ff[CAT_AFTER];
         default:    s3_sel_in = '0;
      endcase
   end

   always_comb begin
      if (s3_bad_ff) begin
         out_val_in = '0;
      end else if (s3_all_ff) begin
         out_val_in = s3_p01_ff + s3_p23_ff;
      end else begin
         out_val_in = s3_sel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s2_lanes_ff <= in_lanes;
         s2_ctl_ff   <= in_ctl;
      end
      if (s2_adv) begin
         s3_p01_ff <= s2_lanes_ff[CAT_READ] + s2_lanes_ff[CAT_WRITE];
         s3_p23_ff <= s2_lanes_ff[CAT_FLUSH] + s2_lanes_ff[CAT_TRIM];
         s3_sel_ff <= s3_sel_in;
         s3_all_ff <= s2_ctl_ff.cat == CAT_ALL;
         s3_bad_ff <= s2_ctl_ff.bad;
      end
      if (s3_adv) begin
         out_val_ff <= out_val_in;
         out_bad_ff <= s3_bad_ff;
      end
   end

   assign rsp_if.valid         = out_v_ff;
   assign rsp_if.stat_value    = out_val_ff;
   assign rsp_if.query_invalid = out_bad_ff;

   `ASSERT_CLK(a_bad_zero, clock, reset, out_v_ff && out_bad_ff |-> out_val_ff == 64'd0, "invalid query with value")
   `ASSERT_CLK(a_out_src, clock, reset, $rose(out_v_ff) |-> $past(s3_v_ff), "response from empty stage")
   `ASSERT_NEVER(a_s2_overrun, clock, reset, in_valid && s2_v_ff && !s2_adv, "lane stage overwritten")

endmodule
`default_nettype wire

[src/block_command_latency_stats_top.sv]
// Query path: input register, then the lane, pair-sum and output register stages.
// Throughput: one beat per cycle unless a query waits on back-pressure; record and
// clear beats update in the cycle after acceptance.
// Reset: synchronous, active high; restores the codes, masks and all twelve records.
// ----------------------------------------------------------------------------
// Block command latency statistics top level
// Input register, configuration registers, record bank and query pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module block_command_latency_stats_top import bcls_pkg::*; #(
   parameter int LATENCY_BITS = 48
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bcls_req_if.sink                  req_if,
   bcls_rsp_if.source                rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cfg_type           cfg_ff;
   logic              s1_v_ff, s1_v_in;
   opcode_type        s1_op_ff;
   logic              s1_ok_ff;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [DUR_W-1:0]  s1_dur_ff;
   logic [BYTE_W-1:0] s1_bytes_ff;
   logic [2:0]        s1_cat_ff;
   logic [1:0]        s1_outc_ff;
   logic [2:0]        s1_ctr_ff;
   logic              s1_adv, q_ready, q_fire, upd_en, clr_en, req_fire;
   query_ctl_type     q_ctl;
   lanes_type         lanes;

   assign req_fire     = req_if.valid && req_if.ready;
   assign s1_adv       = s1_v_ff && (s1_op_ff != OP_QUERY || q_ready);
   assign req_if.ready = !s1_v_ff || s1_adv;
   assign s1_v_in      = req_fire || (s1_v_ff && !s1_adv);
   assign q_fire       = s1_v_ff && s1_op_ff == OP_QUERY && q_ready;
   assign upd_en       = s1_v_ff && s1_op_ff == OP_RECORD;
   assign clr_en       = s1_v_ff && s1_op_ff == OP_CLEAR;

   always_comb begin
      q_ctl.cat = s1_cat_ff;
      q_ctl.bad = s1_outc_ff > OUT_BOTH || s1_ctr_ff > CTR_MIN || s1_cat_ff > CAT_ALL
                  || (s1_cat_ff == CAT_ALL && !(s1_ctr_ff inside {CTR_CALLS, CTR_BYTES}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_code   <= 8'd1;
         cfg_ff.write_code  <= 8'd2;
         cfg_ff.flush_code  <= 8'd3;
         cfg_ff.trim_code   <= 8'd4;
         cfg_ff.before_mask <= 32'd256;
         cfg_ff.after_mask  <= 32'd512;
      end else if (csr_we) begin
         case (csr_index)
            CSR_READ_CODE:   cfg_ff.read_code   <= csr_wdata[CODE_W-1:0];
            CSR_WRITE_CODE:  cfg_ff.write_code  <= csr_wdata[CODE_W-1:0];
            CSR_FLUSH_CODE:  cfg_ff.flush_code  <= csr_wdata[CODE_W-1:0];
            CSR_TRIM_CODE:   cfg_ff.trim_code   <= csr_wdata[CODE_W-1:0];
            CSR_BEFORE_MASK: cfg_ff.before_mask <= csr_wdata[MASK_W-1:0];
            CSR_AFTER_MASK:  cfg_ff.after_mask  <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= opcode_type'(req_if.opcode);
         s1_ok_ff    <= req_if.succeeded;
         s1_cmd_ff   <= req_if.command_word;
         s1_dur_ff   <= req_if.duration;
         s1_bytes_ff <= req_if.byte_count;
         s1_cat_ff   <= req_if.query_category;
         s1_outc_ff  <= req_if.query_outcome;
         s1_ctr_ff   <= req_if.query_counter;
      end
   end

   bcls_bank #(
      .LATENCY_BITS(LATENCY_BITS)
   ) u_bank (
      .clock    (clock),
      .reset    (reset),
      .upd_en   (upd_en),
      .clr_en   (clr_en),
      .cfg      (cfg_ff),
      .ok       (s1_ok_ff),
      .cmd      (s1_cmd_ff),
      .dur      (s1_dur_ff),
      .bytes_in (s1_bytes_ff),
      .outc     (s1_outc_ff),
      .ctr      (s1_ctr_ff),
      .lanes    (lanes)
   );

   bcls_query u_query (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_fire),
      .in_ctl   (q_ctl),
      .in_lanes (lanes),
      .in_ready (q_ready),
      .rsp_if   (rsp_if)
   );

endmodule
`default_nettype wire

[sim/bcls_stats_checker.sv]
// ----------------------------------------------------------------------------
// Command latency statistics checker
// Watches the request, response and register ports, keeps its own copy of the
// twelve records and the codes and masks, and compares every response beat
// with the oldest predicted counter value and invalid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bcls_stats_checker import bcls_pkg::*; #(
   parameter int LATENCY_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   bcls_req_if                  req_mon,
   bcls_rsp_if                  rsp_mon,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   error_count,
   output int                   pending_results,
   output int                   queries_checked,
   output int                   completions_seen
);

   localparam logic [63:0] LAT_ALL = (64'd1 << LATENCY_BITS) - 64'd1;

   typedef struct packed {
      logic [STAT_W-1:0] value;
      logic              invalid;
   } stat_reply_t;

   cfg_type     cfg;
   logic [63:0] call_total[NUM_REC];
   logic [63:0] tick_total[NUM_REC];
   logic [63:0] byte_total[NUM_REC];
   logic [63:0] peak_lat[NUM_REC];
   logic [63:0] floor_lat[NUM_REC];
   stat_reply_t reply_q[$];
   stat_reply_t oldest;
   int          errors = 0;
   int          answered = 0;
   int          recorded = 0;

   function automatic void clear_records();
      for (int r = 0; r < NUM_REC; r++) begin
         call_total[r] = '0;
         tick_total[r] = '0;
         byte_total[r] = '0;
         peak_lat[r]   = '0;
         floor_lat[r]  = LAT_ALL;
      end
   endfunction

   function automatic void account(logic [2:0] cat, logic ok, logic [DUR_W-1:0] dur,
                                   logic [BYTE_W-1:0] nbytes);
      int          r;
      logic [63:0] lat;
      r   = int'(cat) * 2 + int'(ok);
      lat = (64'(dur) > LAT_ALL) ? LAT_ALL : 64'(dur);
      call_total[r] += 64'd1;
      tick_total[r] += 64'(dur);
      byte_total[r] += nbytes;
      if (lat > peak_lat[r]) peak_lat[r] = lat;
      if (lat < floor_lat[r]) floor_lat[r] = lat;
   endfunction

   function automatic logic [63:0] pair_value(logic [2:0] cat, logic [1:0] outc,
                                              logic [2:0] ctr);
      int          f;
      logic [63:0] a;
      logic [63:0] b;
      f = int'(cat) * 2;
      case (ctr)
         CTR_CALLS: begin a = call_total[f]; b = call_total[f+1]; end
         CTR_TIME:  begin a = tick_total[f]; b = tick_total[f+1]; end
         CTR_BYTES: begin a = byte_total[f]; b = byte_total[f+1]; end
         CTR_MAX:   begin a = peak_lat[f];   b = peak_lat[f+1];   end
         default:   begin a = floor_lat[f];  b = floor_lat[f+1];  end
      endcase
      if (outc == OUT_FAIL) return a;
      if (outc == OUT_OK) return b;
      if (ctr == CTR_MAX) return (a > b) ? a : b;
      if (ctr == CTR_MIN) return (a < b) ? a : b;
      return a + b;
   endfunction

   function automatic stat_reply_t answer(logic [2:0] cat, logic [1:0] outc, logic [2:0] ctr);
      stat_reply_t rep;
      rep = '0;
      if (outc > OUT_BOTH || ctr > CTR_MIN) begin
         rep.invalid = 1'b1;
      end else if (cat <= CAT_AFTER) begin
         rep.value = pair_value(cat, outc, ctr);
      end else if (cat == CAT_ALL && (ctr == CTR_CALLS || ctr == CTR_BYTES)) begin
         for (int c = int'(CAT_READ); c <= int'(CAT_TRIM); c++)
            rep.value += pair_value(3'(c), outc, ctr);
      end else begin
         rep.invalid = 1'b1;
      end
      if (rep.invalid) rep.value = '0;
      return rep;
   endfunction

   function automatic void record_completion(logic ok, logic [CMD_W-1:0] cmd,
                                             logic [DUR_W-1:0] dur, logic [BYTE_W-1:0] nbytes);
      logic [CODE_W-1:0] op;
      op = cmd[CODE_W-1:0];
      if (op == cfg.write_code) account(CAT_WRITE, ok, dur, nbytes);
      else if (op == cfg.read_code) account(CAT_READ, ok, dur, nbytes);
      else if (op == cfg.flush_code) account(CAT_FLUSH, ok, dur, nbytes);
      else if (op == cfg.trim_code) account(CAT_TRIM, ok, dur, nbytes);
      if ((cmd & cfg.before_mask) == cfg.before_mask) account(CAT_BEFORE, ok, dur, nbytes);
      if ((cmd & cfg.after_mask) == cfg.after_mask) account(CAT_AFTER, ok, dur, nbytes);
      recorded++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.read_code   = 8'd1;
         cfg.write_code  = 8'd2;
         cfg.flush_code  = 8'd3;
         cfg.trim_code   = 8'd4;
         cfg.before_mask = 32'd256;
         cfg.after_mask  = 32'd512;
         clear_records();
         reply_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reply_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response beat, stat_value %h query_invalid %b",
                        $time, rsp_mon.stat_value, rsp_mon.query_invalid);
            end else begin
               oldest = reply_q.pop_front();
               answered++;
               if (rsp_mon.stat_value !== oldest.value) begin
                  errors++;
                  $display("%0t: stat_value expected %h, got %h",
                           $time, oldest.value, rsp_mon.stat_value);
               end
               if (rsp_mon.query_invalid !== oldest.invalid) begin
                  errors++;
                  $display("%0t: query_invalid expected %b, got %b",
                           $time, oldest.invalid, rsp_mon.query_invalid);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_READ_CODE:   cfg.read_code   = csr_wdata[CODE_W-1:0];
               CSR_WRITE_CODE:  cfg.write_code  = csr_wdata[CODE_W-1:0];
               CSR_FLUSH_CODE:  cfg.flush_code  = csr_wdata[CODE_W-1:0];
               CSR_TRIM_CODE:   cfg.trim_code   = csr_wdata[CODE_W-1:0];
               CSR_BEFORE_MASK: cfg.before_mask = csr_wdata[MASK_W-1:0];
               CSR_AFTER_MASK:  cfg.after_mask  = csr_wdata[MASK_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.opcode)
               OP_RECORD: record_completion(req_mon.succeeded, req_mon.command_word,
                                            req_mon.duration, req_mon.byte_count);
               OP_QUERY:  reply_q.push_back(answer(req_mon.query_category,
                                                   req_mon.query_outcome,
                                                   req_mon.query_counter));
               OP_CLEAR:  clear_records();
               default: ;
            endcase
         end
      end
      error_count      <= errors;
      pending_results  <= reply_q.size();
      queries_checked  <= answered;
      completions_seen <= recorded;
   end

endmodule

[sim/tb_block_command_latency_stats_top.sv]
// ----------------------------------------------------------------------------
// Command latency statistics testbench
// Drives directed and random record, query and clear beats through several
// code and mask settings and idle mixes, including a long response hold,
// and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_block_command_latency_stats_top;
   import bcls_pkg::*;

   localparam logic [1:0]           OP_UNUSED    = 2'd3;
   localparam logic [2:0]           CAT_SPARE    = 3'd7;
   localparam logic [1:0]           OUT_SPARE    = 2'd3;
   localparam logic [2:0]           CTR_SPARE_LO = 3'd5;
   localparam logic [2:0]           CTR_SPARE_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [DUR_W-1:0]     DUR_TOP      = '1;
   localparam logic [BYTE_W-1:0]    BYTE_TOP     = '1;
   localparam int                   SETTLE       = 8;

   typedef struct packed {
      logic [1:0]        opcode;
      logic              succeeded;
      logic [CMD_W-1:0]  cmd;
      logic [DUR_W-1:0]  dur;
      logic [BYTE_W-1:0] nbytes;
      logic [2:0]        cat;
      logic [1:0]        outc;
      logic [2:0]        ctr;
   } beat_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   hold_left = 0;
   cfg_type              active_cfg;
   cfg_type              setting[4];
   int                   error_count;
   int                   pending_results;
   int                   queries_checked;
   int                   completions_seen;

   bcls_req_if req_bus ();
   bcls_rsp_if rsp_bus ();

   block_command_latency_stats_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bcls_stats_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_results  (pending_results),
      .queries_checked  (queries_checked),
      .completions_seen (completions_seen)
   );

   always #5 clock = ~clock;

   // hold off for a counted stretch, else stall at random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   function automatic beat_t noise_beat();
      beat_t b;
      b.opcode    = 2'($urandom);
      b.succeeded = 1'($urandom);
      b.cmd       = $urandom;
      b.dur       = {16'($urandom), 32'($urandom)};
      b.nbytes    = {$urandom, $urandom};
      b.cat       = 3'($urandom);
      b.outc      = 2'($urandom);
      b.ctr       = 3'($urandom);
      return b;
   endfunction

   function automatic beat_t record_beat(logic ok, logic [CMD_W-1:0] cmd,
                                         logic [DUR_W-1:0] dur, logic [BYTE_W-1:0] nbytes);
      beat_t b;
      b           = noise_beat();
      b.opcode    = OP_RECORD;
      b.succeeded = ok;
      b.cmd       = cmd;
      b.dur       = dur;
      b.nbytes    = nbytes;
      return b;
   endfunction

   function automatic beat_t query_beat(logic [2:0] cat, logic [1:0] outc, logic [2:0] ctr);
      beat_t b;
      b        = noise_beat();
      b.opcode = OP_QUERY;
      b.cat    = cat;
      b.outc   = outc;
      b.ctr    = ctr;
      return b;
   endfunction

   function automatic beat_t plain_beat(logic [1:0] opcode);
      beat_t b;
      b        = noise_beat();
      b.opcode = opcode;
      return b;
   endfunction

   function automatic beat_t random_query();
      return query_beat(($urandom_range(0, 15) == 0) ? CAT_SPARE : 3'($urandom_range(0, 6)),
                        ($urandom_range(0, 15) == 0) ? OUT_SPARE : 2'($urandom_range(0, 2)),
                        ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4)));
   endfunction

   function automatic beat_t random_beat();
      beat_t             b;
      int                pick;
      logic [CODE_W-1:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         b = noise_beat();
         b.opcode = OP_RECORD;
         case ($urandom_range(0, 4))
            0:       code = active_cfg.read_code;
            1:       code = active_cfg.write_code;
            2:       code = active_cfg.flush_code;
            3:       code = active_cfg.trim_code;
            default: code = 8'($urandom);
         endcase
         if ($urandom_range(0, 1)) b.cmd |= active_cfg.before_mask;
         if ($urandom_range(0, 1)) b.cmd |= active_cfg.after_mask;
         b.cmd[CODE_W-1:0] = code;
         case ($urandom_range(0, 9))
            0:          b.dur = '0;
            1:          b.dur = DUR_TOP;
            2, 3, 4, 5: b.dur = DUR_W'($urandom_range(0, 1000));
            default: ;
         endcase
         case ($urandom_range(0, 9))
            0:          b.nbytes = '0;
            1:          b.nbytes = BYTE_TOP;
            2, 3, 4, 5: b.nbytes = BYTE_W'($urandom_range(0, 65536));
            default: ;
         endcase
      end else if (pick < 95) begin
         b = random_query();
      end else if (pick < 97) begin
         b = plain_beat(OP_CLEAR);
      end else begin
         b = plain_beat(OP_UNUSED);
      end
      return b;
   endfunction

   task automatic send(input beat_t b);
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= b.opcode;
      req_bus.succeeded      <= b.succeeded;
      req_bus.command_word   <= b.cmd;
      req_bus.duration       <= b.dur;
      req_bus.byte_count     <= b.nbytes;
      req_bus.query_category <= b.cat;
      req_bus.query_outcome  <= b.outc;
      req_bus.query_counter  <= b.ctr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_results();
      if (req_bus.valid) req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_cfg(input cfg_type c);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      write_reg(CSR_READ_CODE, {24'($urandom), c.read_code});
      write_reg(CSR_WRITE_CODE, {24'($urandom), c.write_code});
      write_reg(CSR_FLUSH_CODE, {24'($urandom), c.flush_code});
      write_reg(CSR_TRIM_CODE, {24'($urandom), c.trim_code});
      write_reg(CSR_BEFORE_MASK, c.before_mask);
      write_reg(CSR_AFTER_MASK, c.after_mask);
      write_reg(CSR_SPARE_LO, $urandom);
      write_reg(CSR_SPARE_HI, $urandom);
      csr_we     <= 1'b0;
      active_cfg  = c;
   endtask

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.opcode         = OP_RECORD;
      req_bus.succeeded      = 1'b0;
      req_bus.command_word   = '0;
      req_bus.duration       = '0;
      req_bus.byte_count     = '0;
      req_bus.query_category = CAT_READ;
      req_bus.query_outcome  = OUT_FAIL;
      req_bus.query_counter  = CTR_CALLS;
      rsp_bus.ready          = 1'b0;
      active_cfg = '{read_code: 8'd1, write_code: 8'd2, flush_code: 8'd3, trim_code: 8'd4,
                     before_mask: 32'd256, after_mask: 32'd512};
      setting[0] = '{read_code: 8'h00, write_code: 8'hFF, flush_code: 8'h80, trim_code: 8'h7F,
                     before_mask: 32'hFFFF_FFFF, after_mask: 32'h0000_0000};
      setting[1] = '{read_code: 8'h2A, write_code: 8'h2A, flush_code: 8'h2A, trim_code: 8'h2A,
                     before_mask: 32'h0000_0001, after_mask: 32'h8000_0000};
      setting[2] = '{read_code: 8'h11, write_code: 8'h22, flush_code: 8'h33, trim_code: 8'h44,
                     before_mask: $urandom & $urandom & $urandom,
                     after_mask: $urandom & $urandom & $urandom};
      setting[3] = '{read_code: 8'($urandom), write_code: 8'($urandom),
                     flush_code: 8'($urandom), trim_code: 8'($urandom),
                     before_mask: $urandom & $urandom, after_mask: $urandom & $urandom};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(query_beat(CAT_READ, OUT_FAIL, CTR_MIN));
      send(query_beat(CAT_READ, OUT_BOTH, CTR_MAX));
      send(query_beat(CAT_ALL, OUT_BOTH, CTR_TIME));
      send(record_beat(1'b1, 32'h0000_0001, '0, '0));
      send(record_beat(1'b0, 32'h0000_0301, DUR_TOP, BYTE_TOP));
      send(record_beat(1'b1, 32'h0000_0002, 48'd1000, 64'h8000_0000_0000_0000));
      send(record_beat(1'b1, 32'hFFFF_FF00, 48'd77, 64'd4096));
      send(record_beat(1'b0, 32'h0000_0003, 48'd5, 64'd1));
      send(record_beat(1'b1, 32'h0000_0004, 48'd9, 64'd512));
      send(plain_beat(OP_UNUSED));
      send(query_beat(CAT_READ, OUT_BOTH, CTR_MIN));
      send(query_beat(CAT_READ, OUT_BOTH, CTR_MAX));
      send(query_beat(CAT_READ, OUT_BOTH, CTR_BYTES));
      send(query_beat(CAT_WRITE, OUT_OK, CTR_CALLS));
      send(query_beat(CAT_BEFORE, OUT_BOTH, CTR_CALLS));
      send(query_beat(CAT_AFTER, OUT_FAIL, CTR_TIME));
      send(query_beat(CAT_ALL, OUT_BOTH, CTR_CALLS));
      send(query_beat(CAT_ALL, OUT_OK, CTR_BYTES));
      send(query_beat(CAT_ALL, OUT_BOTH, CTR_MIN));
      send(query_beat(CAT_SPARE, OUT_OK, CTR_CALLS));
      send(query_beat(CAT_FLUSH, OUT_SPARE, CTR_CALLS));
      send(query_beat(CAT_TRIM, OUT_OK, CTR_SPARE_LO));
      send(query_beat(CAT_ALL, OUT_FAIL, CTR_SPARE_HI));
      send(plain_beat(OP_CLEAR));
      send(query_beat(CAT_READ, OUT_FAIL, CTR_MIN));

      for (int p = 0; p < 4; p++) begin
         apply_cfg(setting[p]);
         case (p)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 58; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 58; end
            default: begin send_idle_pct = 25; rsp_stall_pct = 25; end
         endcase
         for (int i = 0; i < 220; i++) begin
            if (i == 110) drain_results();
            send(random_beat());
         end
         if (p == 1) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            hold_left     = 300;
            repeat (60) send(random_query());
         end
      end

      drain_results();
      repeat (SETTLE * 2) @(posedge clock);
      $display("Covered %0d completions and %0d checked queries across reset and four other",
               completions_seen, queries_checked);
      $display("code/mask settings, four idle mixes and one long response hold.");
      if (error_count == 0)
         $display("[block_command_latency_stats_top] OK");
      else
         $display("[block_command_latency_stats_top] ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[block_command_latency_stats_top] ERROR");
      $finish;
   end

endmodule
